/* src/mms_pkg.sv */
// Shared types and constants for the mission mode supervisor.
// Used by the channel interfaces, mms_core and mission_mode_supervisor.
`default_nettype none
package mms_pkg;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_HOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAULT_GRACE  = 1'd1;

  localparam logic [CFG_DATA_W-1:0] STARTUP_HOLD_RST = 16'd500;
  localparam logic [CFG_DATA_W-1:0] FAULT_GRACE_RST  = 16'd750;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_PATH   = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;

  typedef enum logic [1:0] {
    MODE_STARTING = 2'd0,
    MODE_TRACK    = 2'd1,
    MODE_COMPLETE = 2'd2,
    MODE_ABORT    = 2'd3
  } mode_t;

  // fault vector bit order: state, command, error, speed, accel, track_err, geofence, nonfinite
  localparam logic [7:0] FAULT_CRITICAL = 8'b1100_1001;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] now_ms;
    logic        path_has_poses;
    logic        flag_state_stale;
    logic        flag_command_stale;
    logic        flag_error_stale;
    logic        flag_speed_exceeded;
    logic        flag_accel_exceeded;
    logic        flag_track_err_exceeded;
    logic        flag_geofence;
    logic        flag_nonfinite;
  } in_req_t;

  typedef struct packed {
    logic [1:0]  mission_mode;
    logic [31:0] stamp_ms;
  } out_res_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_wr_t;

endpackage
`default_nettype wire

/* src/mms_in_if.sv */
// Input request channel of the mission mode supervisor.
// Depends on mms_pkg for the request payload type.
`default_nettype none
interface mms_in_if;
  logic            valid;
  logic            ready;
  mms_pkg::in_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* src/mms_out_if.sv */
// Result channel of the mission mode supervisor.
// Depends on mms_pkg for the result payload type.
`default_nettype none
interface mms_out_if;
  logic              valid;
  logic              ready;
  mms_pkg::out_res_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* src/mission_mode_supervisor.sv */
// Top level of the mission mode supervisor: request and result channels, config port.
// Depends on mms_pkg, mms_in_if, mms_out_if and mms_core.
//
// Usage:
//   in_req carries status, path and tick requests (valid/ready). Status requests
//   replace the eight latched fault flags; path requests with poses mark the
//   trajectory loaded; tick requests advance the mode machine and produce one
//   result on out_res with the mode and the tick's timestamp. Other kinds give
//   no result.
//   cfg_we/cfg_index/cfg_wdata write startup_hold_ms (0) and fault_grace_ms (1);
//   write only while no request is in flight.
//   A tick's result is registered in the output entry, or the skid entry if one waits.
//   Throughput: one request per cycle; the mode logic is a single registered pass
//   and a two-entry output buffer keeps in_req.ready high while one result waits.
//   Stall: with two results held, in_req.ready drops until out_res.ready frees one.
//   Reset (rst_n low, synchronous): mode STARTING, faults and flags clear,
//   config back to 500 ms hold and 750 ms grace, output buffer empty.
`default_nettype none
module mission_mode_supervisor #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  mms_in_if.sink                               in_req,
  mms_out_if.source                            out_res,
  input  wire logic                            cfg_we,
  input  wire logic [mms_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mms_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  logic              accept;
  logic              push;
  mms_pkg::out_res_t res;
  mms_pkg::cfg_wr_t  cfg;

  logic              out_valid_r, out_valid_nxt;
  mms_pkg::out_res_t out_data_r, out_data_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  mms_pkg::out_res_t skid_data_r, skid_data_nxt;
  logic              pop;

  assign in_req.ready = !skid_valid_r;
  assign accept       = in_req.valid && !skid_valid_r;
  assign cfg          = '{we: cfg_we, index: cfg_index, wdata: cfg_wdata};

  mms_core #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .accept(accept),
    .req   (in_req.payload),
    .cfg   (cfg),
    .push  (push),
    .res   (res)
  );

  assign pop             = out_valid_r && out_res.ready;
  assign out_res.valid   = out_valid_r;
  assign out_res.payload = out_data_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    priority if (skid_valid_r) begin
      if (pop) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (!out_valid_r || pop) begin
      out_valid_nxt = push;
      out_data_nxt  = res;
    end else begin
      if (push) begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a result ahead of output");
  a_tick_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_req.payload.mode == mms_pkg::KIND_TICK && !out_valid_r) |=> out_valid_r)
    else $error("tick result lost");
`endif

endmodule
`default_nettype wire

/* src/mms_core.sv */
// Mode state machine, fault latch and configuration registers.
// Depends on mms_pkg; instantiated by mission_mode_supervisor.
`default_nettype none
module mms_core #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire mms_pkg::in_req_t  req,
  input  wire mms_pkg::cfg_wr_t  cfg,
  output logic                   push,
  output mms_pkg::out_res_t      res
);

  logic [mms_pkg::CFG_DATA_W-1:0] hold_r, hold_nxt;
  logic [mms_pkg::CFG_DATA_W-1:0] grace_r, grace_nxt;
  mms_pkg::mode_t                 mode_r, mode_nxt;
  logic [7:0]                     faults_r, faults_nxt;
  logic                           seen_r, seen_nxt;
  logic                           path_r, path_nxt;
  logic                           rv_r, rv_nxt;
  logic [TIME_WIDTH-1:0]          start_r, start_nxt;
  logic [TIME_WIDTH-1:0]          entry_r, entry_nxt;

  logic [TIME_WIDTH+31:0] now_ext;
  logic [TIME_WIDTH-1:0]  now;
  logic [TIME_WIDTH+31:0] stamp_ext;
  logic [TIME_WIDTH-1:0]  eff_start;
  logic [TIME_WIDTH-1:0]  since_ready;
  logic [TIME_WIDTH-1:0]  since_entry;
  logic [7:0]             req_faults;
  logic                   critical;
  logic                   startup_ok;
  logic                   in_grace;

  assign now_ext     = {{TIME_WIDTH{1'b0}}, req.now_ms};
  assign now         = now_ext[TIME_WIDTH-1:0];
  assign stamp_ext   = {32'd0, now};
  assign eff_start   = rv_r ? start_r : now;
  assign since_ready = now - eff_start;
  assign since_entry = now - entry_r;
  assign critical    = |(faults_r & mms_pkg::FAULT_CRITICAL);
  assign startup_ok  = path_r && !critical;
  assign in_grace    = since_entry < TIME_WIDTH'(grace_r);
  assign req_faults  = {req.flag_nonfinite, req.flag_geofence, req.flag_track_err_exceeded,
                        req.flag_accel_exceeded, req.flag_speed_exceeded,
                        req.flag_error_stale, req.flag_command_stale, req.flag_state_stale};

  always_comb begin
    hold_nxt   = hold_r;
    grace_nxt  = grace_r;
    mode_nxt   = mode_r;
    faults_nxt = faults_r;
    seen_nxt   = seen_r;
    path_nxt   = path_r;
    rv_nxt     = rv_r;
    start_nxt  = start_r;
    entry_nxt  = entry_r;
    push       = 1'b0;

    if (cfg.we) begin
      unique case (cfg.index)
        mms_pkg::CFG_STARTUP_HOLD: hold_nxt  = cfg.wdata;
        mms_pkg::CFG_FAULT_GRACE:  grace_nxt = cfg.wdata;
        default: ;
      endcase
    end

    if (accept) begin
      unique case (req.mode)
        mms_pkg::KIND_STATUS: begin
          faults_nxt = req_faults;
          seen_nxt   = 1'b1;
        end
        mms_pkg::KIND_PATH: begin
          if (req.path_has_poses) begin
            path_nxt = 1'b1;
          end
        end
        mms_pkg::KIND_TICK: begin
          push = 1'b1;
          if (!seen_r) begin
            mode_nxt = mms_pkg::MODE_STARTING;
            rv_nxt   = 1'b0;
          end else begin
            unique case (mode_r)
              mms_pkg::MODE_STARTING: begin
                if (startup_ok) begin
                  rv_nxt    = 1'b1;
                  start_nxt = eff_start;
                  if (since_ready > TIME_WIDTH'(hold_r)) begin
                    mode_nxt  = mms_pkg::MODE_TRACK;
                    entry_nxt = now;
                  end
                end else begin
                  rv_nxt = 1'b0;
                end
              end
              mms_pkg::MODE_TRACK: begin
                if (critical || (!in_grace && (faults_r != 8'd0))) begin
                  mode_nxt = mms_pkg::MODE_ABORT;
                end
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end

    res.mission_mode = mode_nxt;
    res.stamp_ms     = stamp_ext[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r   <= mms_pkg::STARTUP_HOLD_RST;
      grace_r  <= mms_pkg::FAULT_GRACE_RST;
      mode_r   <= mms_pkg::MODE_STARTING;
      faults_r <= 8'd0;
      seen_r   <= 1'b0;
      path_r   <= 1'b0;
      rv_r     <= 1'b0;
    end else begin
      hold_r   <= hold_nxt;
      grace_r  <= grace_nxt;
      mode_r   <= mode_nxt;
      faults_r <= faults_nxt;
      seen_r   <= seen_nxt;
      path_r   <= path_nxt;
      rv_r     <= rv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_r <= start_nxt;
    entry_r <= entry_nxt;
  end

`ifndef SYNTHESIS
  a_abort_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == mms_pkg::MODE_ABORT |=> mode_r == mms_pkg::MODE_ABORT)
    else $error("abort left");
  a_no_complete: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r != mms_pkg::MODE_COMPLETE)
    else $error("complete entered");
  a_start_before_status: assert property (@(posedge clk) disable iff (!rst_n)
    !seen_r |-> (mode_r == mms_pkg::MODE_STARTING && !rv_r))
    else $error("mode moved before status");
  a_track_needs_path: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r != mms_pkg::MODE_STARTING |-> (path_r && seen_r))
    else $error("left startup without path");
`endif

endmodule
`default_nettype wire
